### sv/vmpf_pkg.sv
// Shared constants, codes and types of the voxel population filter.
// Used by every module and interface of the block but vmpf_ram; depends on nothing.
`default_nettype none

package vmpf_pkg;

	// Table geometry: the slot count is a power of two, so the home slot and
	// the probe wrap are plain masks.
	localparam int SLOT_BITS   = 12;
	localparam int TABLE_SLOTS = 1 << SLOT_BITS;
	localparam int COUNT_BITS  = 16;

	localparam int COORD_BITS  = 32;
	localparam int KEY_BITS    = 32;
	localparam int EDGE_BITS   = 31;
	localparam int MINP_BITS   = 16;
	localparam int POP_BITS    = 16;

	// Input commands.
	typedef logic [1:0] cmd_t;
	localparam cmd_t CMD_CLEAR    = 2'd0;
	localparam cmd_t CMD_COUNT    = 2'd1;
	localparam cmd_t CMD_CLASSIFY = 2'd2;
	localparam cmd_t CMD_NONE     = 2'd3;

	// Configuration register indexes.
	localparam logic CFG_VOXEL_EDGE = 1'b0;
	localparam logic CFG_MIN_POINTS = 1'b1;

	localparam logic [EDGE_BITS-1:0] EDGE_RESET = 31'd16384;
	localparam logic [MINP_BITS-1:0] MINP_RESET = 16'd100;

	// Key and hash multipliers.
	localparam logic [KEY_BITS-1:0] KEY_MUL_X = 32'd2000;
	localparam logic [KEY_BITS-1:0] KEY_MUL_Y = 32'd1000;
	localparam logic [KEY_BITS-1:0] HASH_MUL  = 32'h9E37_79B1;

	// One classified item on its way from the front to the back.
	typedef struct packed {
		cmd_t                 cmd;
		logic [KEY_BITS-1:0]  key;
		logic [SLOT_BITS-1:0] slot;
	} job_t;

	// One table entry as it is stored in the slot memory.
	typedef struct packed {
		logic                  valid;
		logic [KEY_BITS-1:0]   key;
		logic [COUNT_BITS-1:0] count;
	} slot_t;

	localparam int SLOT_W = $bits(slot_t);

	// Status from the back part to the front part.
	typedef struct packed {
		logic init_busy;
	} back_stat_t;

endpackage

`default_nettype wire

### sv/vmpf_if.sv
// Valid/ready channel interfaces for points and results of the filter.
// Depends on vmpf_pkg for field widths and the command type.
`default_nettype none

interface vmpf_point_if import vmpf_pkg::*; ();
	logic                         valid;
	logic                         ready;
	cmd_t                         command;
	logic signed [COORD_BITS-1:0] coord_x;
	logic signed [COORD_BITS-1:0] coord_y;
	logic signed [COORD_BITS-1:0] coord_z;

	modport source(output valid, command, coord_x, coord_y, coord_z, input ready);
	modport sink(input valid, command, coord_x, coord_y, coord_z, output ready);
endinterface

interface vmpf_result_if import vmpf_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                keep_point;
	logic [POP_BITS-1:0] voxel_population;
	logic                status;

	modport source(output valid, keep_point, voxel_population, status, input ready);
	modport sink(input valid, keep_point, voxel_population, status, output ready);
endinterface

`default_nettype wire

### sv/voxel_min_population_filter_unit.sv
// Voxel population filter: bins points into voxels by a hashed slot table and
// tells whether a point's voxel is well populated. Channels are valid/ready
// interfaces; a transfer happens when valid and ready are both high.
// The points channel carries a command and a Q16.16 point; clear gives no
// result, count and classify give one result each, an unused command is dropped.
// The front divides the three coordinates (one quotient bit per cycle), then
// forms key and hash in its KEYZ, HASH and MIX states; it takes no new point
// before the job of the last one is in the queue. The back reads the slot
// memory in an ISSUE and a LOOK state per probe until a hit, an empty slot or
// the last slot, then fills the result register.
// A clear empties the table with a sweep in the back; points behind it wait
// in the two-entry queue.
// After reset the back sweeps the whole table, and the points channel shows
// ready low until that sweep ends; configuration writes are taken at all
// times. Registers: index 0 voxel_edge (reset 0.25), index 1 min_points (reset
// 100). A result waits in the output register while the receiver stalls; the
// front works on until the queue is full, and the back stops at its next result.
`default_nettype none

module voxel_min_population_filter_unit import vmpf_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	vmpf_point_if.sink                points,
	vmpf_result_if.source             results,
	input  wire logic                 cfg_we,
	input  wire logic                 cfg_index,
	input  wire logic [EDGE_BITS-1:0] cfg_data
);

	logic [EDGE_BITS-1:0] voxel_edge_q;
	logic [MINP_BITS-1:0] min_points_q;
	logic                 push_valid;
	logic                 push_ready;
	job_t                 push_data;
	logic                 pop_valid;
	logic                 pop_ready;
	job_t                 pop_data;
	back_stat_t           stat;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			voxel_edge_q <= EDGE_RESET;
			min_points_q <= MINP_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_VOXEL_EDGE: voxel_edge_q <= cfg_data;
				CFG_MIN_POINTS: min_points_q <= cfg_data[MINP_BITS-1:0];
				default: ;
			endcase
		end
	end

	vmpf_front u_front (
		.clk(clk), .arst_n(arst_n), .points(points), .voxel_edge(voxel_edge_q),
		.stat(stat), .push_valid(push_valid), .push_ready(push_ready),
		.push_data(push_data)
	);

	vmpf_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push_valid(push_valid), .push_ready(push_ready),
		.push_data(push_data), .pop_valid(pop_valid), .pop_ready(pop_ready),
		.pop_data(pop_data)
	);

	vmpf_back u_back (
		.clk(clk), .arst_n(arst_n), .min_points(min_points_q), .pop_valid(pop_valid),
		.pop_ready(pop_ready), .pop_data(pop_data), .stat(stat), .results(results)
	);

endmodule

`default_nettype wire

### sv/vmpf_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// Stand-alone; width and depth come from its parameters.
`default_nettype none

module vmpf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

### sv/vmpf_divider.sv
// Restoring radix-2 divider: signed coordinate over the voxel edge, truncated
// toward zero, one quotient bit per cycle. Depends on vmpf_pkg.
`default_nettype none

module vmpf_divider import vmpf_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic [COORD_BITS-1:0] dividend,
	input  wire logic [EDGE_BITS-1:0]  divisor,
	output logic                       done,
	output logic      [COORD_BITS-1:0] quotient
);

	localparam int CNT_BITS = $clog2(COORD_BITS);

	logic                  busy_q;
	logic                  done_q;
	logic [CNT_BITS-1:0]   cnt_q;
	logic                  neg_q;
	logic [COORD_BITS-1:0] num_q;
	logic [COORD_BITS-1:0] rem_q;
	logic [COORD_BITS-1:0] den_q;
	logic [COORD_BITS:0]   rem_sh;
	logic [COORD_BITS:0]   rem_sub;
	logic                  ge;

	// One restoring step: shift in the next dividend bit and try a subtract.
	assign rem_sh  = {rem_q, num_q[COORD_BITS-1]};
	assign ge      = rem_sh >= {1'b0, den_q};
	assign rem_sub = rem_sh - {1'b0, den_q};

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_BITS'(COORD_BITS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Datapath: the magnitude is divided, the sign is restored at the end.
	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[COORD_BITS-1];
			num_q <= dividend[COORD_BITS-1] ? (~dividend + 1'b1) : dividend;
			rem_q <= '0;
			den_q <= (divisor == '0) ? COORD_BITS'(1) : {1'b0, divisor};
		end else if (busy_q) begin
			rem_q <= ge ? rem_sub[COORD_BITS-1:0] : rem_sh[COORD_BITS-1:0];
			num_q <= {num_q[COORD_BITS-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = neg_q ? (~num_q + 1'b1) : num_q;

endmodule

`default_nettype wire

### sv/vmpf_front.sv
// Front part: accepts points, divides the coordinates, forms the voxel key
// and its home slot, and hands a job to the queue. Depends on vmpf_pkg,
// vmpf_if and vmpf_divider.
`default_nettype none

module vmpf_front import vmpf_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	vmpf_point_if.sink                points,
	input  wire logic [EDGE_BITS-1:0] voxel_edge,
	input  wire back_stat_t           stat,
	output logic                      push_valid,
	input  wire logic                 push_ready,
	output job_t                      push_data
);

	typedef enum logic [2:0] {
		F_IDLE,
		F_DIV,
		F_KEYZ,
		F_HASH,
		F_MIX,
		F_PUSH
	} fstate_t;

	fstate_t             state_q;
	cmd_t                cmd_q;
	logic [KEY_BITS-1:0] part_q;
	logic [KEY_BITS-1:0] key_q;
	logic [KEY_BITS-1:0] hash_q;
	job_t                job_q;

	logic                  accept;
	logic                  div_start;
	logic                  done_x, done_y, done_z;
	logic [COORD_BITS-1:0] q_x, q_y, q_z;
	logic [KEY_BITS-1:0]   part_d;
	logic [KEY_BITS-1:0]   key_d;
	logic [KEY_BITS-1:0]   hash_d;
	logic [KEY_BITS-1:0]   mix;

	assign points.ready = (state_q == F_IDLE) && !stat.init_busy;
	assign accept       = points.valid && points.ready;
	assign div_start    = accept && (points.command == CMD_COUNT ||
		points.command == CMD_CLASSIFY);

	// Three coordinate dividers run in lockstep.
	vmpf_divider u_div_x (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(points.coord_x),
		.divisor(voxel_edge), .done(done_x), .quotient(q_x)
	);
	vmpf_divider u_div_y (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(points.coord_y),
		.divisor(voxel_edge), .done(done_y), .quotient(q_y)
	);
	vmpf_divider u_div_z (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(points.coord_z),
		.divisor(voxel_edge), .done(done_z), .quotient(q_z)
	);

	// Key and hash arithmetic, at most one multiply per step, all modulo 2^32.
	assign part_d = q_x * KEY_MUL_X + q_y;
	assign key_d  = part_q * KEY_MUL_Y + q_z;
	assign hash_d = key_q * HASH_MUL;
	assign mix    = hash_q ^ (hash_q >> 15);

	// Sequencer with its registered outputs.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (accept) begin
						cmd_q <= points.command;
						if (points.command == CMD_CLEAR) begin
							job_q   <= '{cmd: CMD_CLEAR, key: '0, slot: '0};
							state_q <= F_PUSH;
						end else if (points.command != CMD_NONE) begin
							state_q <= F_DIV;
						end
					end
				end
				F_DIV: begin
					if (done_x && done_y && done_z) begin
						part_q  <= part_d;
						state_q <= F_KEYZ;
					end
				end
				F_KEYZ: begin
					key_q   <= key_d;
					state_q <= F_HASH;
				end
				F_HASH: begin
					hash_q  <= hash_d;
					state_q <= F_MIX;
				end
				F_MIX: begin
					job_q   <= '{cmd: cmd_q, key: key_q, slot: mix[SLOT_BITS-1:0]};
					state_q <= F_PUSH;
				end
				F_PUSH: begin
					if (push_ready) begin
						state_q <= F_IDLE;
					end
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end

	assign push_valid = (state_q == F_PUSH);
	assign push_data  = job_q;

endmodule

`default_nettype wire

### sv/vmpf_queue.sv
// Two-entry job queue between the front and the back parts.
// Depends on vmpf_pkg for the job type.
`default_nettype none

module vmpf_queue import vmpf_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push_valid,
	output logic      push_ready,
	input  wire job_t push_data,
	output logic      pop_valid,
	input  wire logic pop_ready,
	output job_t      pop_data
);

	job_t       entry_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       do_push;
	logic       do_pop;

	assign push_ready = (cnt_q != 2'd2);
	assign pop_valid  = (cnt_q != 2'd0);
	assign pop_data   = entry_q[rd_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) begin
				wr_q <= ~wr_q;
			end
			if (do_pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

### sv/vmpf_back.sv
// Back part: probes the slot table linearly, updates counts, sweeps the table
// on reset and on clear, and holds the result register. Depends on vmpf_pkg,
// vmpf_if and vmpf_ram.
`default_nettype none

module vmpf_back import vmpf_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic [MINP_BITS-1:0] min_points,
	input  wire logic                 pop_valid,
	output logic                      pop_ready,
	input  wire job_t                 pop_data,
	output back_stat_t                stat,
	vmpf_result_if.source             results
);

	typedef enum logic [1:0] {
		B_SWEEP,
		B_IDLE,
		B_ISSUE,
		B_LOOK
	} bstate_t;

	bstate_t              state_q;
	logic                 init_q;
	logic [SLOT_BITS-1:0] idx_q;
	logic [SLOT_BITS-1:0] probes_q;
	job_t                 job_q;
	logic                 out_valid_q;
	logic                 keep_q;
	logic [POP_BITS-1:0]  pop_q;
	logic                 status_q;

	slot_t                 rd;
	logic [SLOT_W-1:0]     rdata;
	logic                  we;
	slot_t                 wdata;
	logic                  hit;
	logic                  empty;
	logic                  last;
	logic                  finish;
	logic                  out_free;
	logic                  produce;
	logic                  is_count;
	logic [COUNT_BITS-1:0] pop_new;
	logic [31:0]           pop_wide;

	vmpf_ram #(
		.WIDTH(SLOT_W),
		.DEPTH(TABLE_SLOTS)
	) u_slots (
		.clk(clk), .we(we), .waddr(idx_q), .wdata(wdata), .raddr(idx_q), .rdata(rdata)
	);

	// Probe decision on the slot just read.
	assign rd       = slot_t'(rdata);
	assign hit      = rd.valid && (rd.key == job_q.key);
	assign empty    = !rd.valid;
	assign last     = (probes_q == SLOT_BITS'(TABLE_SLOTS - 1));
	assign finish   = (state_q == B_LOOK) && (hit || empty || last);
	assign out_free = !out_valid_q || results.ready;
	assign produce  = finish && out_free;
	assign is_count = (job_q.cmd == CMD_COUNT);

	// New population: a count counts on at a hit and saturates, and starts at one in a fresh slot.
	always_comb begin
		if (hit) begin
			pop_new = (is_count && rd.count != '1) ? rd.count + 1'b1 : rd.count;
		end else if (empty && is_count) begin
			pop_new = COUNT_BITS'(1);
		end else begin
			pop_new = '0;
		end
	end
	assign pop_wide = 32'(pop_new);

	// Table write: zeros during a sweep, the updated entry after a count.
	assign we    = (state_q == B_SWEEP) || (produce && is_count && (hit || empty));
	assign wdata = (state_q == B_SWEEP) ? '0 :
		'{valid: 1'b1, key: job_q.key, count: pop_new};

	assign pop_ready      = (state_q == B_IDLE);
	assign stat.init_busy = init_q;

	// Sequencer with its registered outputs.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_SWEEP;
			init_q      <= 1'b1;
			idx_q       <= '0;
			probes_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// The result register fills at a finished probe and empties at a transfer.
			if (produce) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				B_SWEEP: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q == SLOT_BITS'(TABLE_SLOTS - 1)) begin
						init_q  <= 1'b0;
						state_q <= B_IDLE;
					end
				end
				B_IDLE: begin
					if (pop_valid) begin
						job_q    <= pop_data;
						probes_q <= '0;
						if (pop_data.cmd == CMD_CLEAR) begin
							idx_q   <= '0;
							state_q <= B_SWEEP;
						end else begin
							idx_q   <= pop_data.slot;
							state_q <= B_ISSUE;
						end
					end
				end
				B_ISSUE: begin
					state_q <= B_LOOK;
				end
				B_LOOK: begin
					if (finish) begin
						if (out_free) begin
							keep_q      <= (pop_wide >= 32'(min_points));
							pop_q       <= (pop_wide > 32'hFFFF) ? 16'hFFFF
								: pop_wide[POP_BITS-1:0];
							status_q    <= is_count && !hit && !empty;
							state_q     <= B_IDLE;
						end
					end else begin
						idx_q    <= idx_q + 1'b1;
						probes_q <= probes_q + 1'b1;
						state_q  <= B_ISSUE;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

	assign results.valid            = out_valid_q;
	assign results.keep_point       = keep_q;
	assign results.voxel_population = pop_q;
	assign results.status           = status_q;

`ifndef SYNTH
	// A full table reports no population.
	a_full_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q |-> pop_q == '0) else $error("full status with population");

	// Sweep writes only empty entries.
	a_sweep_clears: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == B_SWEEP |-> we && !wdata.valid) else $error("sweep wrote a valid slot");

	// A new result comes only out of a probe.
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == B_LOOK) else $error("result without probe");

	// The power-up sweep ends only from the sweep state.
	a_init_end: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(init_q) |-> $past(state_q) == B_SWEEP) else $error("init ended early");
`endif

endmodule

`default_nettype wire

### dv/vmpf_tb_pkg.sv
// Test helpers for the voxel population filter: point and result records.
// Depends on vmpf_pkg for the command type and field widths.
`default_nettype none

package vmpf_tb_pkg;
	import vmpf_pkg::*;

	// One point as it is offered on the points channel.
	typedef struct {
		cmd_t                         cmd;
		logic signed [COORD_BITS-1:0] x;
		logic signed [COORD_BITS-1:0] y;
		logic signed [COORD_BITS-1:0] z;
	} point_t;

	// One result as it is seen on the results channel.
	typedef struct {
		logic                keep;
		logic [POP_BITS-1:0] pop;
		logic                status;
	} verdict_t;

endpackage

`default_nettype wire

### dv/voxel_min_population_filter_unit_test.sv
// Testbench of the voxel population filter: drives points with random idling,
// predicts each result with its own slot table and checks every transfer.
// Depends on vmpf_pkg, vmpf_tb_pkg, the channel interfaces and the block.
`default_nettype none

module voxel_min_population_filter_unit_test;
	import vmpf_pkg::*;
	import vmpf_tb_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 3000000;
	localparam int DRAIN_CYCLES = 200;
	localparam int CLEAR_CYCLES = 4200;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_index = CFG_VOXEL_EDGE;
	logic [EDGE_BITS-1:0] cfg_data = '0;

	vmpf_point_if points();
	vmpf_result_if results();

	voxel_min_population_filter_unit dut (
		.clk(clk), .arst_n(arst_n), .points(points.sink), .results(results.source),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// Predictor state: configuration and the slot table.
	logic [EDGE_BITS-1:0]  edge_len;
	logic [MINP_BITS-1:0]  min_pop;
	logic [KEY_BITS-1:0]   tbl_key[TABLE_SLOTS];
	logic [COUNT_BITS-1:0] tbl_count[TABLE_SLOTS];
	bit                    tbl_used[TABLE_SLOTS];

	verdict_t pending_verdicts[$];
	int errors = 0;
	int cycles = 0;
	int send_idle = 8;
	int recv_idle = 52;

	// Appends one expectation at the tail of the pending list.
	function automatic void queue_verdict(verdict_t v);
		pending_verdicts.insert(pending_verdicts.size(), v);
	endfunction

	// Truncating signed division of one coordinate by the voxel edge.
	function automatic logic [31:0] cell_of(logic [31:0] c);
		logic [31:0] mag;
		logic [31:0] d;
		logic [31:0] q;
		mag = c[31] ? -c : c;
		d = (edge_len == '0) ? 32'd1 : {1'b0, edge_len};
		q = mag / d;
		return c[31] ? -q : q;
	endfunction

	function automatic logic [SLOT_BITS-1:0] home_of(logic [31:0] key);
		logic [31:0] h;
		h = key * HASH_MUL;
		h = h ^ (h >> 15);
		return h[SLOT_BITS-1:0];
	endfunction

	// Applies one point to the predicted table; returns 1 if it yields a result.
	function automatic bit predict_point(point_t p, output verdict_t v);
		logic [31:0] key;
		logic [SLOT_BITS-1:0] idx;
		logic [COUNT_BITS-1:0] pop;
		bit found;
		bit stored;
		if (p.cmd == CMD_CLEAR) begin
			foreach (tbl_used[i]) tbl_used[i] = 1'b0;
			return 1'b0;
		end
		if (p.cmd == CMD_NONE)
			return 1'b0;
		key = (cell_of(p.x) * KEY_MUL_X + cell_of(p.y)) * KEY_MUL_Y + cell_of(p.z);
		idx = home_of(key);
		pop = '0;
		found = 1'b0;
		stored = 1'b0;
		for (int n = 0; n < TABLE_SLOTS && !found; n++) begin
			if (!tbl_used[idx]) begin
				if (p.cmd == CMD_COUNT) begin
					tbl_used[idx] = 1'b1;
					tbl_key[idx] = key;
					tbl_count[idx] = '0;
					stored = 1'b1;
				end
				found = 1'b1;
			end else if (tbl_key[idx] == key) begin
				stored = 1'b1;
				found = 1'b1;
			end else begin
				idx = idx + 1'b1;
			end
		end
		if (stored) begin
			if (p.cmd == CMD_COUNT && tbl_count[idx] != '1)
				tbl_count[idx] = tbl_count[idx] + 1'b1;
			pop = tbl_count[idx];
		end
		v.status = (p.cmd == CMD_COUNT) && !stored;
		v.pop = pop;
		v.keep = pop >= min_pop;
		return 1'b1;
	endfunction

	task automatic write_reg(logic index, logic [EDGE_BITS-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (index == CFG_VOXEL_EDGE)
			edge_len = value;
		else
			min_pop = value[MINP_BITS-1:0];
	endtask

	// Sends one point; the expectation is queued at its transfer. Valid drops
	// only while the sender idles, so it changes only at a falling edge.
	task automatic send_point(point_t p, bit typed, verdict_t typed_v);
		verdict_t v;
		while ($urandom_range(99) < send_idle) begin
			points.valid <= 1'b0;
			@(negedge clk);
		end
		points.valid <= 1'b1;
		points.command <= p.cmd;
		points.coord_x <= p.x;
		points.coord_y <= p.y;
		points.coord_z <= p.z;
		do @(posedge clk); while (!points.ready);
		if (predict_point(p, v))
			queue_verdict(typed ? typed_v : v);
		@(negedge clk);
	endtask

	task automatic wait_idle();
		points.valid <= 1'b0;
		while (pending_verdicts.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	function automatic logic [31:0] rand_coord(int mode);
		case (mode)
			0: return $urandom();
			1: return $urandom_range(16384 * 4) - 32768;
			default: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom())};
		endcase
	endfunction

	// Receiver: random stall, check each result transfer.
	always @(negedge clk) begin
		if (arst_n)
			results.ready <= ($urandom_range(99) >= recv_idle);
	end

	always @(posedge clk) begin
		verdict_t e;
		cycles <= cycles + 1;
		if (results.valid && results.ready) begin
			if (pending_verdicts.size() == 0) begin
				$error("result transfer with nothing expected");
				errors++;
			end else begin
				e = pending_verdicts.pop_front();
				if (results.keep_point !== e.keep) begin
					$error("keep_point: expected %0b, got %0b", e.keep, results.keep_point);
					errors++;
				end
				if (results.voxel_population !== e.pop) begin
					$error("voxel_population: expected %0d, got %0d", e.pop,
						results.voxel_population);
					errors++;
				end
				if (results.status !== e.status) begin
					$error("status: expected %0b, got %0b", e.status, results.status);
					errors++;
				end
			end
		end
		if (cycles >= CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Directed rows: command, point, and a typed result where it is obvious.
	typedef struct {
		point_t   p;
		bit       typed;
		verdict_t v;
	} row_t;

	row_t rows[$];

	function automatic void add_row(point_t p, bit typed, verdict_t v);
		row_t r;
		r.p = p;
		r.typed = typed;
		r.v = v;
		rows.insert(rows.size(), r);
	endfunction

	initial begin
		point_t p;
		verdict_t none;
		int phase_items;
		none = '{keep: 1'b0, pop: '0, status: 1'b0};
		points.valid = 1'b0;
		points.command = CMD_NONE;
		points.coord_x = '0;
		points.coord_y = '0;
		points.coord_z = '0;
		results.ready = 1'b0;
		edge_len = EDGE_RESET;
		min_pop = MINP_RESET;
		foreach (tbl_used[i]) tbl_used[i] = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Absent voxel after reset, then counts, extremes, unused command, clear and a classify after it.
		add_row('{CMD_CLASSIFY, 0, 0, 0}, 1'b1, '{1'b0, 16'd0, 1'b0});
		add_row('{CMD_COUNT, 0, 0, 0}, 1'b1, '{1'b0, 16'd1, 1'b0});
		add_row('{CMD_COUNT, 0, 0, 0}, 1'b1, '{1'b0, 16'd2, 1'b0});
		add_row('{CMD_CLASSIFY, 100, 200, 300}, 1'b1, '{1'b0, 16'd2, 1'b0});
		add_row('{CMD_COUNT, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF}, 1'b0, none);
		add_row('{CMD_COUNT, 32'h80000000, 32'h80000000, 32'h80000000}, 1'b0, none);
		add_row('{CMD_COUNT, -16384, 16383, -1}, 1'b0, none);
		add_row('{CMD_CLASSIFY, 32'h80000000, 32'h80000000, 32'h80000000}, 1'b0, none);
		add_row('{CMD_NONE, 0, 0, 0}, 1'b0, none);
		add_row('{CMD_CLEAR, 0, 0, 0}, 1'b0, none);
		add_row('{CMD_CLASSIFY, 0, 0, 0}, 1'b1, '{1'b0, 16'd0, 1'b0});
		foreach (rows[i]) send_point(rows[i].p, rows[i].typed, rows[i].v);
		wait_idle();
		repeat (CLEAR_CYCLES) @(negedge clk);

		// Random phases over register settings, extremes included.
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin write_reg(CFG_VOXEL_EDGE, 31'd0); write_reg(CFG_MIN_POINTS, 31'd0); end
				1: begin write_reg(CFG_VOXEL_EDGE, 31'h7FFFFFFF);
					write_reg(CFG_MIN_POINTS, 31'h0000FFFF); end
				2: begin write_reg(CFG_VOXEL_EDGE, 31'd65536);
					write_reg(CFG_MIN_POINTS, 31'd3); end
				3: begin send_idle = 52; recv_idle = 8;
					write_reg(CFG_VOXEL_EDGE, 31'd16384); write_reg(CFG_MIN_POINTS, 31'd5); end
				4: begin write_reg(CFG_VOXEL_EDGE, 31'($urandom()));
					write_reg(CFG_MIN_POINTS, 31'd2); end
				default: begin send_idle = 0; recv_idle = 0;
					write_reg(CFG_VOXEL_EDGE, 31'd8192); write_reg(CFG_MIN_POINTS, 31'd4); end
			endcase
			phase_items = 155;
			for (int i = 0; i < phase_items; i++) begin
				int mode;
				int r;
				mode = (ph == 1) ? 0 : $urandom_range(2);
				r = $urandom_range(99);
				p.cmd = (r < 55) ? CMD_COUNT : (r < 97) ? CMD_CLASSIFY :
					(r < 99) ? CMD_NONE : CMD_CLEAR;
				p.x = rand_coord(mode);
				p.y = rand_coord(mode);
				p.z = rand_coord(mode);
				send_point(p, 1'b0, none);
			end
			wait_idle();
			repeat (CLEAR_CYCLES) @(negedge clk);
		end

		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

`default_nettype wire
